>>> rtl/core/rmm_pkg.sv
// Shared types, constants and helpers for the range min/max segment tree.
// Used by every module under rtl/core; depends on nothing.
package rmm_pkg;

  localparam int unsigned ELEMENTS_DEF = 1024;

  localparam int IDX_W       = 10;
  localparam int VAL_W       = 31;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  localparam logic [VAL_W-1:0] NO_MIN    = 31'd2000000000;
  localparam logic [VAL_W-1:0] TOP_VALUE = 31'd1999999999;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] mn;
    logic [VAL_W-1:0] mx;
  } node_t;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] elem_index;
    logic [VAL_W-1:0] elem_value;
    logic [IDX_W-1:0] range_start;
    logic [IDX_W-1:0] range_end;
  } item_t;

  typedef struct packed {
    node_t bound;
    logic  empty;
  } result_t;

  localparam node_t NODE_IDENT = '{mn: NO_MIN, mx: '0};

  function automatic node_t node_merge(node_t a, node_t b);
    node_t m;
    m.mn = (a.mn < b.mn) ? a.mn : b.mn;
    m.mx = (a.mx > b.mx) ? a.mx : b.mx;
    return m;
  endfunction

endpackage

>>> rtl/core/rmm_node_mem.sv
// Node store: one min/max word per tree node, one write and one read port.
// Read data is registered. Depends on rmm_pkg.
module rmm_node_mem #(
  parameter int DEPTH = 2 * rmm_pkg::ELEMENTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  rmm_pkg::node_t wdata,
  input  logic [AW-1:0]  raddr,
  output rmm_pkg::node_t rdata
);

  rmm_pkg::node_t mem [DEPTH];
  rmm_pkg::node_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/rmm_engine.sv
// Sequencer for the segment tree: clearing pass after reset, leaf-to-root
// update for loads, bottom-up range walk for queries. Depends on rmm_pkg, rmm_node_mem.
module rmm_engine #(
  parameter int unsigned ELEMENTS = rmm_pkg::ELEMENTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  rmm_pkg::item_t   item,
  input  logic             res_free,
  output logic             res_valid,
  output rmm_pkg::result_t result
);

  localparam int NODES = 2 * ELEMENTS;
  localparam int NW    = $clog2(NODES);
  // arithmetic width: holds node numbers up to 2*ELEMENTS and any raw index
  localparam int AW    = (NW + 1 > rmm_pkg::IDX_W + 1) ? NW + 1 : rmm_pkg::IDX_W + 1;

  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [AW-1:0] ELEM_A    = AW'(ELEMENTS);
  localparam logic [AW-1:0] ONE_A     = AW'(1);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_LD_LEAF = 8'b0000_0100,
    S_LD_UP   = 8'b0000_1000,
    S_Q_SETUP = 8'b0001_0000,
    S_Q_L     = 8'b0010_0000,
    S_Q_R     = 8'b0100_0000,
    S_DRAIN   = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  rmm_pkg::item_t          item_r, item_nxt;
  logic [AW-1:0]           l_r, l_nxt;
  logic [AW-1:0]           r_r, r_nxt;
  rmm_pkg::node_t          carry_r, carry_nxt;
  rmm_pkg::node_t          acc_r, acc_nxt;
  logic                    empty_r, empty_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic [NW-1:0]           clr_r, clr_nxt;

  logic                    mem_we;
  logic [NW-1:0]           mem_waddr;
  rmm_pkg::node_t          mem_wdata;
  logic [NW-1:0]           mem_raddr;
  rmm_pkg::node_t          mem_rdata;

  rmm_pkg::node_t          acc_merged;
  rmm_pkg::node_t          up_node;
  logic [rmm_pkg::VAL_W-1:0] sat_val;
  logic [AW-1:0]           idx_a, first_a, last_a, last_c, leaf_k, parent_k, r_dec;

  rmm_node_mem #(
    .DEPTH (NODES),
    .AW    (NW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign acc_merged = rd_pend_r ? rmm_pkg::node_merge(acc_r, mem_rdata) : acc_r;
  assign up_node    = rmm_pkg::node_merge(carry_r, mem_rdata);
  assign sat_val    = (item_r.elem_value > rmm_pkg::TOP_VALUE) ? rmm_pkg::TOP_VALUE
                                                               : item_r.elem_value;
  assign idx_a      = AW'(item_r.elem_index);
  assign first_a    = AW'(item_r.range_start);
  assign last_a     = AW'(item_r.range_end);
  assign last_c     = (last_a >= ELEM_A) ? ELEM_A - ONE_A : last_a;
  assign leaf_k     = idx_a + ELEM_A;
  assign parent_k   = l_r >> 1;
  assign r_dec      = r_r[0] ? r_r - ONE_A : r_r;

  assign result     = '{bound: acc_merged, empty: empty_r};

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    l_nxt       = l_r;
    r_nxt       = r_r;
    carry_nxt   = carry_r;
    acc_nxt     = acc_merged;
    empty_nxt   = empty_r;
    rd_pend_nxt = 1'b0;
    clr_nxt     = clr_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = rmm_pkg::NODE_IDENT;
    mem_raddr   = '0;
    item_ready  = 1'b0;
    res_valid   = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + NW'(1);
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          item_nxt  = item;
          state_nxt = (item.op == rmm_pkg::OP_QUERY) ? S_Q_SETUP : S_LD_LEAF;
        end
      end
      S_LD_LEAF: begin
        if (idx_a >= ELEM_A) begin
          state_nxt = S_IDLE;          // index past the array: dropped
        end else begin
          mem_we    = 1'b1;
          mem_waddr = leaf_k[NW-1:0];
          mem_wdata = '{mn: sat_val, mx: sat_val};
          carry_nxt = '{mn: sat_val, mx: sat_val};
          mem_raddr = {leaf_k[NW-1:1], ~leaf_k[0]};
          l_nxt     = leaf_k;
          state_nxt = S_LD_UP;
        end
      end
      S_LD_UP: begin
        // sibling arrived; write parent and, below the root, fetch the parent's sibling
        mem_we    = 1'b1;
        mem_waddr = parent_k[NW-1:0];
        mem_wdata = up_node;
        carry_nxt = up_node;
        l_nxt     = parent_k;
        if (parent_k > ONE_A) begin
          mem_raddr = {parent_k[NW-1:1], ~parent_k[0]};
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_Q_SETUP: begin
        acc_nxt = rmm_pkg::NODE_IDENT;
        if (first_a > last_c) begin
          empty_nxt = 1'b1;
          state_nxt = S_DRAIN;
        end else begin
          empty_nxt = 1'b0;
          l_nxt     = first_a + ELEM_A;
          r_nxt     = last_c + ELEM_A + ONE_A;
          state_nxt = S_Q_L;
        end
      end
      S_Q_L: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            mem_raddr   = l_r[NW-1:0];
            rd_pend_nxt = 1'b1;
            l_nxt       = l_r + ONE_A;
          end
          state_nxt = S_Q_R;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_Q_R: begin
        if (r_r[0]) begin
          mem_raddr   = r_dec[NW-1:0];
          rd_pend_nxt = 1'b1;
        end
        l_nxt     = l_r >> 1;
        r_nxt     = r_dec >> 1;
        state_nxt = S_Q_L;
      end
      S_DRAIN: begin
        if (res_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    carry_r <= carry_nxt;
    acc_r   <= acc_nxt;
    empty_r <= empty_nxt;
  end

endmodule

>>> rtl/core/rmm_out_stage.sv
// Result register between the sequencer and the output channel; frees the
// sequencer as soon as a result is parked. Depends on rmm_pkg.
module rmm_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  rmm_pkg::result_t result,
  output logic             res_free,
  output logic             out_valid,
  input  logic             out_ready,
  output rmm_pkg::result_t out_result
);

  logic             valid_r, valid_nxt;
  rmm_pkg::result_t result_r;

  assign res_free  = !valid_r || out_ready;
  assign valid_nxt = res_valid || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

>>> rtl/core/range_min_max_segment_tree_core.sv
// Range min/max segment tree over ELEMENTS values, one node word per tree node
// in a single memory with one read and one write port; read data is registered.
// After reset a clearing pass fills every node with the identities (min
// 2000000000, max 0); no request is taken until it ends.
// A load does one leaf write, then one step per tree level, each reading the
// sibling and writing the parent. A query keeps the engine busy until its
// bottom-up walk ends, after which the result moves to the output register
// once that register is free: the walk needs up to two node reads per level
// through the single read port. The engine returns to idle before the next
// request is taken. One request is worked at a time; a finished result parks
// in an output register so the next request is taken while it waits.
// Loads produce no result.
// Depends on rmm_pkg, rmm_engine, rmm_node_mem, rmm_out_stage.
module range_min_max_segment_tree_core #(
  parameter int unsigned ELEMENTS = rmm_pkg::ELEMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // elem_index[9:0], elem_value[40:10], range_start[50:41], range_end[60:51]
  input  logic [rmm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // range_min[30:0], range_max[61:31]
  output logic [rmm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // empty_range[0]
  output logic                            out_tuser
);

  rmm_pkg::item_t   item;
  rmm_pkg::result_t result;
  rmm_pkg::result_t out_result;
  logic             res_valid;
  logic             res_free;

  // struct order from the top bit: op, elem_index, elem_value, range_start, range_end
  assign item = {in_tuser, in_tdata[9:0], in_tdata[40:10], in_tdata[50:41],
                 in_tdata[60:51]};

  rmm_engine #(
    .ELEMENTS (ELEMENTS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .res_free   (res_free),
    .res_valid  (res_valid),
    .result     (result)
  );

  rmm_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .result     (result),
    .res_free   (res_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {2'b00, out_result.bound.mx, out_result.bound.mn};
  assign out_tuser = out_result.empty;

endmodule
